// ===== rtl/ftc_pkg.sv =====
// Package for the four-channel counter/timer: command codes, control word bits,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package ftc_pkg;

    // Default and largest channel count.
    localparam int NUM_CHANNELS = 4;
    localparam int MAX_CHANNELS = 8;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CPT_W      = 12;
    localparam logic [CPT_W-1:0] CPT_RESET = 12'd730;

    // Register index of clocks_per_tick.
    localparam logic REG_CLOCKS_PER_TICK = 1'b0;

    // Steps of the reload remainder unit, one quotient bit per cycle.
    localparam int DIV_STEPS = 8;

    // Control word bit positions.
    localparam int CW_IRQ     = 7;
    localparam int CW_COUNTER = 6;
    localparam int CW_PRESCALE = 5;
    localparam int CW_TCONST  = 2;
    localparam int CW_RESET   = 1;
    localparam int CW_CONTROL = 0;

    // Control word after reset: reset bit only.
    localparam logic [7:0] CW_RESET_VALUE = 8'h02;

    // Mask applied to the vector base.
    localparam logic [7:0] VECTOR_MASK = 8'hF8;

    // Request command codes.
    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_RETI  = 3'd3,
        CMD_POLL  = 3'd4
    } ftc_cmd_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK_CHK,
        ST_TICK_DIV,
        ST_TICK_FIN,
        ST_DONE
    } ftc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic chk;
        logic div_step;
        logic fin;
        logic load_out;
    } ftc_dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic need_div;
    } ftc_dp_stat_t;

endpackage

// ===== rtl/ftc_in_if.sv =====
// Request channel interface of the counter/timer: valid, ready and request fields.
// No dependencies.
interface ftc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [1:0] channel;
    logic [7:0] write_data;
    logic       outside_claim;

    modport source (output valid, output cmd, output channel, output write_data,
                    output outside_claim, input ready);
    modport sink   (input valid, input cmd, input channel, input write_data,
                    input outside_claim, output ready);
endinterface

// ===== rtl/ftc_out_if.sv =====
// Result channel interface of the counter/timer: valid, ready and result fields.
// No dependencies.
interface ftc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_raise;
    logic [7:0] irq_vector;
    logic [1:0] irq_channel;
    logic [3:0] pending_out;

    modport source (output valid, output read_data, output irq_raise, output irq_vector,
                    output irq_channel, output pending_out, input ready);
    modport sink   (input valid, input read_data, input irq_raise, input irq_vector,
                    input irq_channel, input pending_out, output ready);
endinterface

// ===== rtl/ftc_apb.sv =====
// Configuration register bank of the counter/timer behind an APB-style port.
// Depends on ftc_pkg.
module ftc_apb
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ftc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ftc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ftc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [ftc_pkg::CPT_W-1:0]        clocks_per_tick
);

    logic [ftc_pkg::CPT_W-1:0] cpt_reg;
    logic [ftc_pkg::CPT_W-1:0] cpt_next;
    logic                      reg_idx;
    logic                      wr_en;

    // Registers sit on word addresses, so the index is the address above the byte bits.
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Write decode.
    always_comb
    begin
        cpt_next = cpt_reg;
        if (wr_en && (reg_idx == ftc_pkg::REG_CLOCKS_PER_TICK))
        begin
            cpt_next = pwdata[ftc_pkg::CPT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpt_reg <= ftc_pkg::CPT_RESET;
        end
        else
        begin
            cpt_reg <= cpt_next;
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb
    begin
        if (reg_idx == ftc_pkg::REG_CLOCKS_PER_TICK)
        begin
            prdata = ftc_pkg::APB_DATA_W'(cpt_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign clocks_per_tick = cpt_reg;

endmodule

// ===== rtl/ftc_ctrl.sv =====
// Controller of the counter/timer: sequences request execution, the per-channel
// tick walk with its remainder iterations, and the result hand-off. Depends on ftc_pkg.
module ftc_ctrl
#(
    parameter int NUM_CHANNELS = ftc_pkg::NUM_CHANNELS,
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ftc_pkg::ftc_dp_stat_t stat,
    output ftc_pkg::ftc_dp_cmd_t  cmd,
    output logic [CH_W-1:0]       tick_ch
);

    localparam int BIT_W = $clog2(ftc_pkg::DIV_STEPS);

    ftc_pkg::ftc_state_t state_reg;
    ftc_pkg::ftc_state_t state_next;
    logic [CH_W-1:0]     ch_reg;
    logic [CH_W-1:0]     ch_next;
    logic [BIT_W-1:0]    bit_reg;
    logic [BIT_W-1:0]    bit_next;
    logic                ovalid_reg;
    logic                ovalid_next;
    logic                last_ch;
    logic                last_bit;

    assign last_ch  = (ch_reg == CH_W'(NUM_CHANNELS - 1));
    assign last_bit = (bit_reg == BIT_W'(ftc_pkg::DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ftc_pkg::ST_IDLE;
            ch_reg     <= '0;
            bit_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            bit_reg    <= bit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        bit_next    = bit_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        ovalid_next = ovalid_reg;

        // A waiting result leaves once taken.
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ftc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ftc_pkg::ST_EXEC;
                end
            end
            ftc_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                ch_next  = '0;
                if (stat.is_tick)
                begin
                    state_next = ftc_pkg::ST_TICK_CHK;
                end
                else
                begin
                    state_next = ftc_pkg::ST_DONE;
                end
            end
            ftc_pkg::ST_TICK_CHK:
            begin
                cmd.chk = 1'b1;
                if (stat.need_div)
                begin
                    bit_next   = '0;
                    state_next = ftc_pkg::ST_TICK_DIV;
                end
                else if (last_ch)
                begin
                    state_next = ftc_pkg::ST_DONE;
                end
                else
                begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            ftc_pkg::ST_TICK_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + BIT_W'(1);
                if (last_bit)
                begin
                    state_next = ftc_pkg::ST_TICK_FIN;
                end
            end
            ftc_pkg::ST_TICK_FIN:
            begin
                cmd.fin = 1'b1;
                if (last_ch)
                begin
                    state_next = ftc_pkg::ST_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = ftc_pkg::ST_TICK_CHK;
                end
            end
            ftc_pkg::ST_DONE:
            begin
                // Load the output register once it is free or being emptied.
                if (!ovalid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ftc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = ovalid_reg;
    assign tick_ch   = ch_reg;

endmodule

// ===== rtl/ftc_dp.sv =====
// Datapath of the counter/timer: channel counts, reloads, control words, interrupt
// state, the serial remainder unit for underflow and the result register. Depends on ftc_pkg.
module ftc_dp
#(
    parameter int NUM_CHANNELS = ftc_pkg::NUM_CHANNELS,
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ftc_pkg::ftc_dp_cmd_t       cmd,
    input  logic [CH_W-1:0]            tick_ch,
    output ftc_pkg::ftc_dp_stat_t      stat,
    input  logic [ftc_pkg::CPT_W-1:0]  clocks_per_tick,
    input  logic [2:0]                 in_cmd,
    input  logic [1:0]                 in_channel,
    input  logic [7:0]                 in_write_data,
    input  logic                       in_outside_claim,
    output logic [7:0]                 read_data,
    output logic                       irq_raise,
    output logic [7:0]                 irq_vector,
    output logic [1:0]                 irq_channel,
    output logic [3:0]                 pending_out
);

    // Architectural state.
    logic [15:0]             count_reg  [NUM_CHANNELS];
    logic [15:0]             count_next [NUM_CHANNELS];
    logic [7:0]              reload_reg  [NUM_CHANNELS];
    logic [7:0]              reload_next [NUM_CHANNELS];
    logic [7:0]              ctrl_reg  [NUM_CHANNELS];
    logic [7:0]              ctrl_next [NUM_CHANNELS];
    logic [7:0]              vbase_reg;
    logic [7:0]              vbase_next;
    logic [NUM_CHANNELS-1:0] pend_reg;
    logic [NUM_CHANNELS-1:0] pend_next;
    logic                    live_reg;
    logic                    live_next;
    logic [CH_W-1:0]         live_ch_reg;
    logic [CH_W-1:0]         live_ch_next;

    // Latched request.
    logic [2:0]              cmd_reg;
    logic [2:0]              cmd_next;
    logic [1:0]              chan_reg;
    logic [1:0]              chan_next;
    logic [7:0]              data_reg;
    logic [7:0]              data_next;
    logic                    claim_reg;
    logic                    claim_next;

    // Remainder unit.
    logic [7:0]              div_hi_reg;
    logic [7:0]              div_hi_next;
    logic [7:0]              div_lo_reg;
    logic [7:0]              div_lo_next;
    logic [8:0]              div_rem_reg;
    logic [8:0]              div_rem_next;
    logic [8:0]              div_r_reg;
    logic [8:0]              div_r_next;

    // Result under construction and output register.
    logic [7:0]              res_read_reg;
    logic [7:0]              res_read_next;
    logic                    res_raise_reg;
    logic                    res_raise_next;
    logic [7:0]              res_vec_reg;
    logic [7:0]              res_vec_next;
    logic [1:0]              res_ch_reg;
    logic [1:0]              res_ch_next;
    logic [7:0]              out_read_reg;
    logic [7:0]              out_read_next;
    logic                    out_raise_reg;
    logic                    out_raise_next;
    logic [7:0]              out_vec_reg;
    logic [7:0]              out_vec_next;
    logic [1:0]              out_ch_reg;
    logic [1:0]              out_ch_next;
    logic [3:0]              out_pend_reg;
    logic [3:0]              out_pend_next;

    // Tick channel view.
    logic [15:0]             cnt_s;
    logic [7:0]              cw_s;
    logic [7:0]              rel_s;
    logic                    skip_s;
    logic [15:0]             dec_s;
    logic [15:0]             deficit_s;
    logic                    need_div;
    logic [9:0]              trial;
    logic [15:0]             rem16;
    logic [16:0]             step17;
    logic [15:0]             fin_val;

    assign cnt_s     = count_reg[tick_ch];
    assign cw_s      = ctrl_reg[tick_ch];
    assign rel_s     = reload_reg[tick_ch];
    assign skip_s    = (cw_s[ftc_pkg::CW_TCONST] && cw_s[ftc_pkg::CW_RESET])
                       || cw_s[ftc_pkg::CW_COUNTER];
    assign dec_s     = cw_s[ftc_pkg::CW_PRESCALE] ? {4'b0000, clocks_per_tick}
                                                  : {clocks_per_tick, 4'b0000};
    assign deficit_s = dec_s - cnt_s;
    assign need_div  = !skip_s && (dec_s > cnt_s);

    // One restoring step of (deficit >> 8) mod reload; the low byte passes straight.
    assign trial   = {div_rem_reg, div_hi_reg[7]};
    assign rem16   = {div_rem_reg[7:0], div_lo_reg};
    assign step17  = {div_r_reg, 8'h00};
    assign fin_val = (rem16 == 16'h0000) ? 16'h0000 : 16'(step17 - {1'b0, rem16});

    assign stat.is_tick  = (cmd_reg == ftc_pkg::CMD_TICK);
    assign stat.need_div = need_div;

    // Next-state logic for all requests and tick phases.
    always_comb
    begin
        logic [NUM_CHANNELS-1:0] pend_tmp;
        logic                    live_tmp;
        logic                    poll_en;
        logic                    found;
        logic [CH_W-1:0]         sel;
        logic [7:0]              cw;

        count_next     = count_reg;
        reload_next    = reload_reg;
        ctrl_next      = ctrl_reg;
        vbase_next     = vbase_reg;
        pend_next      = pend_reg;
        live_next      = live_reg;
        live_ch_next   = live_ch_reg;
        cmd_next       = cmd_reg;
        chan_next      = chan_reg;
        data_next      = data_reg;
        claim_next     = claim_reg;
        div_hi_next    = div_hi_reg;
        div_lo_next    = div_lo_reg;
        div_rem_next   = div_rem_reg;
        div_r_next     = div_r_reg;
        res_read_next  = res_read_reg;
        res_raise_next = res_raise_reg;
        res_vec_next   = res_vec_reg;
        res_ch_next    = res_ch_reg;
        out_read_next  = out_read_reg;
        out_raise_next = out_raise_reg;
        out_vec_next   = out_vec_reg;
        out_ch_next    = out_ch_reg;
        out_pend_next  = out_pend_reg;
        pend_tmp       = pend_reg;
        live_tmp       = live_reg;
        poll_en        = 1'b0;
        found          = 1'b0;
        sel            = '0;
        cw             = '0;

        // Capture the request.
        if (cmd.accept)
        begin
            cmd_next   = in_cmd;
            chan_next  = in_channel;
            data_next  = in_write_data;
            claim_next = in_outside_claim;
        end

        // Requests executed in the exec phase.
        if (cmd.exec)
        begin
            res_read_next  = '0;
            res_raise_next = 1'b0;
            res_vec_next   = '0;
            res_ch_next    = '0;
            unique case (cmd_reg)
                ftc_pkg::CMD_WRITE:
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if ({2'b00, chan_reg} == 4'(i))
                        begin
                            cw = ctrl_reg[i];
                            if (cw[ftc_pkg::CW_TCONST])
                            begin
                                // Time constant expected: load it and start the channel.
                                reload_next[i] = data_reg;
                                if (cw[ftc_pkg::CW_RESET])
                                begin
                                    count_next[i] = {data_reg - 8'd1, 8'h00};
                                end
                                cw[ftc_pkg::CW_TCONST] = 1'b0;
                                cw[ftc_pkg::CW_RESET]  = 1'b0;
                                ctrl_next[i] = cw;
                            end
                            else if (data_reg[ftc_pkg::CW_CONTROL])
                            begin
                                // Control word.
                                ctrl_next[i] = data_reg;
                                if (!data_reg[ftc_pkg::CW_TCONST] && data_reg[ftc_pkg::CW_RESET])
                                begin
                                    count_next[i] = {reload_reg[i] - 8'd1, 8'h00};
                                end
                                if (!data_reg[ftc_pkg::CW_IRQ] && pend_reg[i])
                                begin
                                    pend_tmp    = pend_reg;
                                    pend_tmp[i] = 1'b0;
                                    pend_next   = pend_tmp;
                                    if ((pend_tmp == '0) && live_reg
                                        && (live_ch_reg == CH_W'(i)))
                                    begin
                                        live_next = 1'b0;
                                    end
                                end
                            end
                            else if (i == 0)
                            begin
                                vbase_next = data_reg;
                            end
                        end
                    end
                end
                ftc_pkg::CMD_READ:
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if ({2'b00, chan_reg} == 4'(i))
                        begin
                            res_read_next = count_reg[i][15:8];
                        end
                    end
                end
                ftc_pkg::CMD_TICK:
                begin
                    // Handled channel by channel in the tick phases.
                end
                ftc_pkg::CMD_RETI:
                begin
                    // Retire the live interrupt, then poll.
                    if (live_reg)
                    begin
                        pend_tmp[live_ch_reg] = 1'b0;
                    end
                    live_tmp  = 1'b0;
                    pend_next = pend_tmp;
                    live_next = 1'b0;
                    poll_en   = 1'b1;
                end
                ftc_pkg::CMD_POLL:
                begin
                    poll_en = 1'b1;
                end
                default:
                begin
                end
            endcase

            // Poll: raise the lowest pending channel if the line is free.
            if (poll_en && !live_tmp && !claim_reg)
            begin
                for (int i = NUM_CHANNELS - 1; i >= 0; i--)
                begin
                    if (pend_tmp[i])
                    begin
                        found = 1'b1;
                        sel   = CH_W'(i);
                    end
                end
                if (found)
                begin
                    live_next      = 1'b1;
                    live_ch_next   = sel;
                    res_raise_next = 1'b1;
                    res_vec_next   = (vbase_reg & ftc_pkg::VECTOR_MASK)
                                     + {3'b000, 4'(sel), 1'b0};
                    res_ch_next    = 2'(sel);
                end
            end
        end

        // Tick: check one channel, subtract, or flag its interrupt and start the remainder unit.
        if (cmd.chk && !skip_s)
        begin
            if (!need_div)
            begin
                count_next[tick_ch] = cnt_s - dec_s;
            end
            else
            begin
                if (cw_s[ftc_pkg::CW_IRQ])
                begin
                    pend_next[tick_ch] = 1'b1;
                end
                div_hi_next  = deficit_s[15:8];
                div_lo_next  = deficit_s[7:0];
                div_rem_next = '0;
                div_r_next   = (rel_s == 8'h00) ? 9'd256 : {1'b0, rel_s};
            end
        end

        // Remainder iteration.
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, div_r_reg})
            begin
                div_rem_next = 9'(trial - {1'b0, div_r_reg});
            end
            else
            begin
                div_rem_next = trial[8:0];
            end
            div_hi_next = {div_hi_reg[6:0], 1'b0};
        end

        // Write back the reloaded count.
        if (cmd.fin)
        begin
            count_next[tick_ch] = fin_val;
        end

        // Output register load.
        if (cmd.load_out)
        begin
            out_read_next  = res_read_reg;
            out_raise_next = res_raise_reg;
            out_vec_next   = res_vec_reg;
            out_ch_next    = res_ch_reg;
            out_pend_next  = 4'(ftc_pkg::MAX_CHANNELS'(pend_reg));
        end
    end

    // Architectural state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
                ctrl_reg[i]   <= ftc_pkg::CW_RESET_VALUE;
            end
            vbase_reg   <= '0;
            pend_reg    <= '0;
            live_reg    <= 1'b0;
            live_ch_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            reload_reg  <= reload_next;
            ctrl_reg    <= ctrl_next;
            vbase_reg   <= vbase_next;
            pend_reg    <= pend_next;
            live_reg    <= live_next;
            live_ch_reg <= live_ch_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        chan_reg      <= chan_next;
        data_reg      <= data_next;
        claim_reg     <= claim_next;
        div_hi_reg    <= div_hi_next;
        div_lo_reg    <= div_lo_next;
        div_rem_reg   <= div_rem_next;
        div_r_reg     <= div_r_next;
        res_read_reg  <= res_read_next;
        res_raise_reg <= res_raise_next;
        res_vec_reg   <= res_vec_next;
        res_ch_reg    <= res_ch_next;
        out_read_reg  <= out_read_next;
        out_raise_reg <= out_raise_next;
        out_vec_reg   <= out_vec_next;
        out_ch_reg    <= out_ch_next;
        out_pend_reg  <= out_pend_next;
    end

    assign read_data   = out_read_reg;
    assign irq_raise   = out_raise_reg;
    assign irq_vector  = out_vec_reg;
    assign irq_channel = out_ch_reg;
    assign pending_out = out_pend_reg;

endmodule

// ===== rtl/four_channel_counter_timer_top.sv =====
// Four-channel counter/timer with vectored interrupts. A write, read, poll or return
// passes through the execute and done states before its result is loaded; a tick walks
// the channels in turn: a check each and, on underflow, 8 remainder steps and a write-back.
// One request is in work at a time; a new one is taken while the result waits.
// Asynchronous active-low reset clears counts, reloads, vector base and interrupt state,
// sets each control word to its reset bit and clocks_per_tick to 730.
module four_channel_counter_timer_top
#(
    parameter int NUM_CHANNELS = ftc_pkg::NUM_CHANNELS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    ftc_in_if.sink                          cmd_chan,
    ftc_out_if.source                       result_chan,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ftc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ftc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ftc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [ftc_pkg::CPT_W-1:0] clocks_per_tick;
    ftc_pkg::ftc_dp_cmd_t      dp_cmd;
    ftc_pkg::ftc_dp_stat_t     dp_stat;
    logic [CH_W-1:0]           tick_ch;

    // Configuration registers.
    ftc_apb u_apb
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .clocks_per_tick (clocks_per_tick)
    );

    // Sequencer.
    ftc_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_chan.valid),
        .in_ready  (cmd_chan.ready),
        .out_valid (result_chan.valid),
        .out_ready (result_chan.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd),
        .tick_ch   (tick_ch)
    );

    // Channel state and arithmetic.
    ftc_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (dp_cmd),
        .tick_ch          (tick_ch),
        .stat             (dp_stat),
        .clocks_per_tick  (clocks_per_tick),
        .in_cmd           (cmd_chan.cmd),
        .in_channel       (cmd_chan.channel),
        .in_write_data    (cmd_chan.write_data),
        .in_outside_claim (cmd_chan.outside_claim),
        .read_data        (result_chan.read_data),
        .irq_raise        (result_chan.irq_raise),
        .irq_vector       (result_chan.irq_vector),
        .irq_channel      (result_chan.irq_channel),
        .pending_out      (result_chan.pending_out)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the four-channel counter/timer: directed requests, then random
// request traffic over several clocks_per_tick settings, checked against a local predictor.
// Depends on ftc_pkg, ftc_in_if, ftc_out_if and four_channel_counter_timer_top.
module testbench;
    import ftc_pkg::*;

    // Run geometry.
    localparam int CHANNELS     = 4;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 400;

    // Register address and spare command codes.
    localparam logic [APB_ADDR_W-1:0] CPT_ADDR = APB_ADDR_W'(4 * REG_CLOCKS_PER_TICK);
    localparam logic [2:0] CMD_SPARE_LO = 3'(CMD_POLL) + 3'd1;
    localparam logic [2:0] CMD_SPARE_HI = 3'b111;

    // Control word bytes.
    localparam logic [7:0] CTL_IRQ      = 8'h01 << CW_IRQ;
    localparam logic [7:0] CTL_COUNTER  = 8'h01 << CW_COUNTER;
    localparam logic [7:0] CTL_PRESCALE = 8'h01 << CW_PRESCALE;
    localparam logic [7:0] CTL_TCONST   = 8'h01 << CW_TCONST;
    localparam logic [7:0] CTL_RESET    = 8'h01 << CW_RESET;
    localparam logic [7:0] CTL_CONTROL  = 8'h01 << CW_CONTROL;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_raise;
        logic [7:0] irq_vector;
        logic [1:0] irq_channel;
        logic [3:0] pending_out;
    } ctc_result_t;

    // Predicts the result of each accepted request and checks results in order.
    class ctc_scoreboard;
        bit [15:0]   count_q [CHANNELS];
        bit [7:0]    reload_q[CHANNELS];
        bit [7:0]    ctrl_q  [CHANNELS];
        bit [7:0]    vector_base;
        bit [3:0]    pending;
        bit          live_valid;
        bit [1:0]    live_ch;
        bit [11:0]   clocks_per_tick;
        ctc_result_t expected_q[$];
        int          errors;
        int          accepted;
        int          checked;
        int          underflows;
        int          raised;

        function new();
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                count_q[ch]  = '0;
                reload_q[ch] = '0;
                ctrl_q[ch]   = CW_RESET_VALUE;
            end
            vector_base     = '0;
            pending         = '0;
            live_valid      = 1'b0;
            live_ch         = '0;
            clocks_per_tick = CPT_RESET;
        endfunction

        function void set_clocks_per_tick(bit [11:0] value);
            clocks_per_tick = value;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Start value of a count after a reload: one less than the constant, in the upper byte.
        function bit [15:0] reload_start(int ch);
            return {reload_q[ch] - 8'd1, 8'h00};
        endfunction

        // Raise the lowest pending channel when the line is free.
        function void raise_lowest(bit claim, inout ctc_result_t r);
            if (live_valid || claim)
                return;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                if (pending[ch])
                begin
                    live_valid    = 1'b1;
                    live_ch       = 2'(ch);
                    r.irq_raise   = 1'b1;
                    r.irq_vector  = (vector_base & VECTOR_MASK) + 8'(2 * ch);
                    r.irq_channel = 2'(ch);
                    raised++;
                    return;
                end
            end
        endfunction

        function void note_request(logic [2:0] cmd, logic [1:0] ch, logic [7:0] data,
                                   logic claim);
            ctc_result_t r;
            int unsigned dec;
            int unsigned stepv;
            int unsigned deficit;
            int unsigned k;
            r = '0;
            accepted++;
            case (cmd)
                CMD_WRITE:
                begin
                    if (ctrl_q[ch][CW_TCONST])
                    begin
                        // A time constant was expected: store it and start the channel.
                        reload_q[ch] = data;
                        if (ctrl_q[ch][CW_RESET])
                            count_q[ch] = reload_start(ch);
                        ctrl_q[ch][CW_TCONST] = 1'b0;
                        ctrl_q[ch][CW_RESET]  = 1'b0;
                    end
                    else if (data[CW_CONTROL])
                    begin
                        ctrl_q[ch] = data;
                        if (data[CW_RESET] && !data[CW_TCONST])
                            count_q[ch] = reload_start(ch);
                        if (!data[CW_IRQ] && pending[ch])
                        begin
                            pending[ch] = 1'b0;
                            if (pending == '0 && live_valid && live_ch == ch)
                                live_valid = 1'b0;
                        end
                    end
                    else if (ch == 0)
                        vector_base = data;
                end
                CMD_READ:
                    r.read_data = count_q[ch][15:8];
                CMD_TICK:
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (ctrl_q[c][CW_TCONST] && ctrl_q[c][CW_RESET])
                            continue;
                        if (ctrl_q[c][CW_COUNTER])
                            continue;
                        dec = clocks_per_tick;
                        if (!ctrl_q[c][CW_PRESCALE])
                            dec = dec << 4;
                        if (dec <= count_q[c])
                        begin
                            count_q[c] = 16'(count_q[c] - dec);
                            continue;
                        end
                        // Underflow: add whole reload periods until the count is no longer negative.
                        underflows++;
                        if (ctrl_q[c][CW_IRQ])
                            pending[c] = 1'b1;
                        stepv   = (reload_q[c] != 0) ? (int'(reload_q[c]) << 8) : (256 << 8);
                        deficit = dec - count_q[c];
                        k       = (deficit + stepv - 1) / stepv;
                        count_q[c] = 16'(k * stepv - deficit);
                    end
                end
                CMD_RETI:
                begin
                    if (live_valid)
                        pending[live_ch] = 1'b0;
                    live_valid = 1'b0;
                    raise_lowest(claim, r);
                end
                CMD_POLL:
                    raise_lowest(claim, r);
                default:
                    ;
            endcase
            r.pending_out = pending;
            expected_q.push_back(r);
        endfunction

        function void check_result(ctc_result_t got);
            ctc_result_t exp_r;
            checked++;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding: %p", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.read_data !== exp_r.read_data)
            begin
                $error("read_data: expected %0d, got %0d", exp_r.read_data, got.read_data);
                errors++;
            end
            if (got.irq_raise !== exp_r.irq_raise)
            begin
                $error("irq_raise: expected %0d, got %0d", exp_r.irq_raise, got.irq_raise);
                errors++;
            end
            if (got.irq_vector !== exp_r.irq_vector)
            begin
                $error("irq_vector: expected %0d, got %0d", exp_r.irq_vector, got.irq_vector);
                errors++;
            end
            if (got.irq_channel !== exp_r.irq_channel)
            begin
                $error("irq_channel: expected %0d, got %0d",
                       exp_r.irq_channel, got.irq_channel);
                errors++;
            end
            if (got.pending_out !== exp_r.pending_out)
            begin
                $error("pending_out: expected %0d, got %0d",
                       exp_r.pending_out, got.pending_out);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    ftc_in_if  cmd_if();
    ftc_out_if res_if();

    ctc_scoreboard sb;
    bit gaps_on;
    int settings_used;

    four_channel_counter_timer_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_chan    (cmd_if),
        .result_chan (res_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle gap length: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one request, after an optional gap, and wait until it is taken.
    task automatic send_request(logic [2:0] cmd, logic [1:0] ch, logic [7:0] data,
                                logic claim);
        int g;
        g = idle_gap();
        if (g > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.cmd           <= cmd;
        cmd_if.channel       <= ch;
        cmd_if.write_data    <= data;
        cmd_if.outside_claim <= claim;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
    endtask

    // Register write over the configuration port: setup cycle, then access cycle.
    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_clocks_per_tick(data[CPT_W-1:0]);
        settings_used++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Let the block run dry: every result in, then a wait before the next phase.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random requests, mostly well-formed channel programming around ticks and polls.
    task automatic random_traffic(int n);
        int sent;
        int r;
        logic [1:0] ch;
        logic [7:0] cw;
        logic [7:0] tc;
        logic claim;
        sent = 0;
        while (sent < n)
        begin
            r     = $urandom_range(0, 99);
            ch    = 2'($urandom_range(0, CHANNELS - 1));
            claim = ($urandom_range(0, 3) == 0);
            if (r < 12)
            begin
                // Control word, followed by its time constant when one is expected.
                cw = 8'($urandom);
                cw[CW_CONTROL] = 1'b1;
                if ($urandom_range(0, 9) < 7)
                begin
                    cw[CW_TCONST] = 1'b1;
                    cw[CW_RESET]  = 1'b1;
                end
                if ($urandom_range(0, 4) != 0)
                    cw[CW_COUNTER] = 1'b0;
                if ($urandom_range(0, 3) != 0)
                    cw[CW_IRQ] = 1'b1;
                send_request(CMD_WRITE, ch, cw, claim);
                sent++;
                if (cw[CW_TCONST])
                begin
                    tc = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
                    send_request(CMD_WRITE, ch, tc, claim);
                    sent++;
                end
            end
            else if (r < 16)
            begin
                cw = 8'($urandom);
                cw[CW_CONTROL] = 1'b1;
                send_request(CMD_WRITE, ch, cw, claim);
                sent++;
            end
            else if (r < 19)
            begin
                cw = 8'($urandom);
                cw[CW_CONTROL] = 1'b0;
                send_request(CMD_WRITE, ($urandom_range(0, 2) == 0) ? ch : 2'd0, cw, claim);
                sent++;
            end
            else
            begin
                if (r < 21)
                    send_request(CMD_WRITE, ch, 8'($urandom), claim);
                else if (r < 30)
                    send_request(CMD_READ, ch, 8'($urandom), claim);
                else if (r < 60)
                    send_request(CMD_TICK, ch, 8'($urandom), claim);
                else if (r < 75)
                    send_request(CMD_RETI, ch, 8'($urandom), claim);
                else if (r < 97)
                    send_request(CMD_POLL, ch, 8'($urandom), claim);
                else
                    send_request(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), ch,
                                 8'($urandom), claim);
                sent++;
            end
        end
    endtask

    // Accepted requests feed the predictor; results are checked against it.
    always @(posedge clk)
    begin : monitor
        ctc_result_t got;
        if (rst_n && sb != null)
        begin
            if (cmd_if.valid && cmd_if.ready)
                sb.note_request(cmd_if.cmd, cmd_if.channel, cmd_if.write_data,
                                cmd_if.outside_claim);
            if (res_if.valid && res_if.ready)
            begin
                got.read_data   = res_if.read_data;
                got.irq_raise   = res_if.irq_raise;
                got.irq_vector  = res_if.irq_vector;
                got.irq_channel = res_if.irq_channel;
                got.pending_out = res_if.pending_out;
                sb.check_result(got);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off that backs the block up.
    initial
    begin : result_sink
        bit hold_done;
        int g;
        hold_done    = 1'b0;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && sb.accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                g = idle_gap();
                if (g > 0)
                begin
                    res_if.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Timeout.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence: reset, directed requests, then random phases at several settings.
    initial
    begin : main_seq
        logic [11:0] cpt_settings[6];
        sb                   = new();
        gaps_on              = 1'b1;
        settings_used        = 0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.cmd           = CMD_READ;
        cmd_if.channel       = '0;
        cmd_if.write_data    = '0;
        cmd_if.outside_claim = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset setting of clocks_per_tick.
        send_request(CMD_READ, 2'd0, 8'h00, 1'b0);
        send_request(CMD_TICK, 2'd0, 8'h00, 1'b0);
        send_request(CMD_WRITE, 2'd0, 8'hFE, 1'b0);
        send_request(CMD_WRITE, 2'd1, 8'h00, 1'b0);
        send_request(CMD_WRITE, 2'd0,
                     CTL_IRQ | CTL_PRESCALE | CTL_TCONST | CTL_RESET | CTL_CONTROL, 1'b0);
        send_request(CMD_WRITE, 2'd0, 8'h01, 1'b0);
        send_request(CMD_WRITE, 2'd1, CTL_IRQ | CTL_TCONST | CTL_RESET | CTL_CONTROL, 1'b0);
        send_request(CMD_WRITE, 2'd1, 8'h00, 1'b0);
        send_request(CMD_WRITE, 2'd2, CTL_IRQ | CTL_COUNTER | CTL_TCONST | CTL_CONTROL, 1'b0);
        send_request(CMD_WRITE, 2'd2, 8'hFF, 1'b0);
        send_request(CMD_WRITE, 2'd3, CTL_IRQ | CTL_RESET | CTL_CONTROL, 1'b0);
        send_request(CMD_TICK, 2'd0, 8'h00, 1'b0);
        send_request(CMD_TICK, 2'd0, 8'h00, 1'b0);
        send_request(CMD_READ, 2'd3, 8'h00, 1'b0);
        send_request(CMD_POLL, 2'd0, 8'h00, 1'b1);
        send_request(CMD_POLL, 2'd0, 8'h00, 1'b0);
        send_request(CMD_POLL, 2'd0, 8'h00, 1'b0);
        send_request(CMD_RETI, 2'd0, 8'h00, 1'b0);
        send_request(CMD_WRITE, 2'd0, CTL_CONTROL, 1'b0);
        send_request(CMD_RETI, 2'd0, 8'h00, 1'b1);
        send_request(CMD_SPARE_LO, 2'd3, 8'hFF, 1'b1);
        send_request(CMD_SPARE_HI, 2'd2, 8'h55, 1'b0);
        send_request(CMD_READ, 2'd1, 8'h00, 1'b0);
        send_request(CMD_READ, 2'd2, 8'h00, 1'b0);
        drain();

        // Random phases, extremes of clocks_per_tick among the settings.
        cpt_settings[0] = 12'd0;
        cpt_settings[1] = 12'hFFF;
        cpt_settings[2] = 12'd1;
        cpt_settings[3] = CPT_RESET;
        cpt_settings[4] = 12'($urandom_range(2, 300));
        cpt_settings[5] = 12'($urandom);
        for (int phase = 0; phase < 6; phase++)
        begin
            apb_write(CPT_ADDR, {20'($urandom), cpt_settings[phase]});
            gaps_on = (phase % 3 != 1);
            random_traffic(PHASE_ITEMS);
            drain();
        end

        $display("Covered %0d requests and %0d results over %0d clocks_per_tick settings,",
                 sb.accepted, sb.checked, settings_used);
        $display("with %0d timer underflows and %0d interrupts raised.",
                 sb.underflows, sb.raised);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ftc_pkg.sv
rtl/ftc_in_if.sv
rtl/ftc_out_if.sv
rtl/ftc_apb.sv
rtl/ftc_ctrl.sv
rtl/ftc_dp.sv
rtl/four_channel_counter_timer_top.sv
bench/testbench.sv
